FILE: rtl/core/s2d_pkg.sv
// ----------------------------------------------------------------------------
// s2d_pkg: shared types and constants
// Widths, ASCII codes and the control group of the BCD digit cells.
// ----------------------------------------------------------------------------
`default_nettype none

package s2d_pkg;

  localparam int ValueWidth = 32;
  localparam int NumDigits  = 10;
  localparam int CharWidth  = 8;

  localparam logic [CharWidth-1:0] CharMinus = 8'd45;
  localparam logic [CharWidth-1:0] CharZero  = 8'd48;

  typedef logic [3:0] digit_t;

  // control shared by every cell of the digit row
  typedef struct packed {
    logic clear;   // start of a new item
    logic dabble;  // add-3 correction and shift in one binary bit
    logic shift;   // move digits one cell toward the top
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/s2d_if.sv
// ----------------------------------------------------------------------------
// s2d_in_if / s2d_out_if: valid-ready channels
// Input channel carries one signed value, output channel one character.
// ----------------------------------------------------------------------------
`default_nettype none

interface s2d_in_if import s2d_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [ValueWidth-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface s2d_out_if import s2d_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CharWidth-1:0] character;
  logic                 last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/s2d_bcd_cell.sv
// ----------------------------------------------------------------------------
// s2d_bcd_cell: one decimal digit of the conversion row
// Holds one BCD digit; does the add-3 and shift step or moves a digit upward.
// ----------------------------------------------------------------------------
`default_nettype none

module s2d_bcd_cell import s2d_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  wire        carry_i,
  input  digit_t     digit_i,
  output logic       carry_o,
  output digit_t     digit_o
);

  digit_t digit_q;
  digit_t digit_d;
  digit_t adj;

  assign adj     = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
  assign carry_o = adj[3];
  assign digit_o = digit_q;

  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.dabble) begin
      digit_d = {adj[2:0], carry_i};
    end else if (ctrl_i.shift) begin
      digit_d = digit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed 32-bit integer to decimal ASCII text
// Double-dabble over a row of ten BCD cells, then digits leave top first.
// ----------------------------------------------------------------------------
// Each input item is one signed 32-bit value; the output gives its decimal
// text one ASCII character per item, a minus sign first for negative values,
// no leading zeros, and last set on the final character. An item is accepted
// while idle, then shifted and corrected bit by bit in the digit row; a sign
// state follows when negative, and then the digit state steps through all ten
// digit positions, leading zeros skipped without output. Output stalls hold
// back the sign and each emitted digit, though not the skipping of leading
// zeros. The next item is taken once the final character sits in the output
// register.
`default_nettype none

module signed_int_to_decimal_ascii import s2d_pkg::*; (
  input  wire          clk_i,
  input  wire          rst_ni,
  s2d_in_if.sink       in_i,
  s2d_out_if.source    out_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_DIGITS
  } state_e;

  state_e                 state_q;
  logic [ValueWidth-1:0]  mag_q;
  logic                   neg_q;
  logic [4:0]             cnt_q;
  logic [3:0]             rem_q;
  logic                   seen_q;
  logic                   out_valid_q;
  logic [CharWidth-1:0]   char_q;
  logic                   last_q;

  cell_ctrl_t             ctrl;
  digit_t                 chain_digit [NumDigits];
  logic                   chain_carry [NumDigits];
  digit_t                 top_digit;
  logic [ValueWidth-1:0]  raw;
  logic                   accept;
  logic                   slot_free;
  logic                   skip;
  logic                   emit_digit;
  logic                   emit_sign;

  for (genvar i = 0; i < NumDigits; i++) begin : g_cell
    if (i == 0) begin : g_first
      s2d_bcd_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (ctrl),
        .carry_i (mag_q[ValueWidth-1]),
        .digit_i (digit_t'(0)),
        .carry_o (chain_carry[i]),
        .digit_o (chain_digit[i])
      );
    end else begin : g_rest
      s2d_bcd_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (ctrl),
        .carry_i (chain_carry[i-1]),
        .digit_i (chain_digit[i-1]),
        .carry_o (chain_carry[i]),
        .digit_o (chain_digit[i])
      );
    end
  end

  assign raw       = in_i.value;
  assign top_digit = chain_digit[NumDigits-1];
  assign in_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.character = char_q;
  assign out_o.last      = last_q;

  always_comb begin
    accept     = in_i.valid && (state_q == ST_IDLE);
    slot_free  = !out_valid_q || out_o.ready;
    // leading zero, never the units digit
    skip       = (state_q == ST_DIGITS) && (top_digit == 4'd0) && !seen_q && (rem_q != 4'd1);
    emit_digit = (state_q == ST_DIGITS) && !skip && slot_free;
    emit_sign  = (state_q == ST_SIGN) && slot_free;
    ctrl.clear  = accept;
    ctrl.dabble = (state_q == ST_CONV);
    ctrl.shift  = skip || emit_digit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mag_q       <= '0;
      neg_q       <= 1'b0;
      cnt_q       <= '0;
      rem_q       <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
      char_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready && !emit_sign && !emit_digit) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            neg_q   <= raw[ValueWidth-1];
            mag_q   <= raw[ValueWidth-1] ? (~raw + 32'd1) : raw;
            cnt_q   <= '0;
            rem_q   <= 4'(NumDigits);
            seen_q  <= 1'b0;
            state_q <= ST_CONV;
          end
        end
        ST_CONV: begin
          mag_q <= {mag_q[ValueWidth-2:0], 1'b0};
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'(ValueWidth - 1)) begin
            state_q <= neg_q ? ST_SIGN : ST_DIGITS;
          end
        end
        ST_SIGN: begin
          if (emit_sign) begin
            out_valid_q <= 1'b1;
            char_q      <= CharMinus;
            last_q      <= 1'b0;
            state_q     <= ST_DIGITS;
          end
        end
        ST_DIGITS: begin
          if (skip) begin
            rem_q <= rem_q - 4'd1;
          end else if (emit_digit) begin
            out_valid_q <= 1'b1;
            char_q      <= CharZero + {4'd0, top_digit};
            last_q      <= (rem_q == 4'd1);
            seen_q      <= 1'b1;
            rem_q       <= rem_q - 4'd1;
            if (rem_q == 4'd1) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // the top cell never overflows: 2^32 - 1 fits in ten digits
  a_no_top_carry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV) |-> !chain_carry[NumDigits-1])
    else $error("digit row overflow during conversion");

  a_digit_bcd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIGITS) |-> (top_digit <= 4'd9))
    else $error("non-decimal digit in top cell");

  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.character == CharMinus)) |-> !out_o.last)
    else $error("minus sign marked as last character");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=>
      (out_o.valid && $stable(out_o.character) && $stable(out_o.last)))
    else $error("waiting output item changed");

  a_accept_starts_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q == ST_CONV) && (cnt_q == 5'd0))
    else $error("accepted item did not start conversion");
`endif

endmodule

`default_nettype wire

FILE: test/signed_int_to_decimal_ascii_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_tb: self-checking bench for the itoa block
// Sends signed values, predicts each value's decimal text and checks every
// character and its last flag, under several idle and stall mixes.
// ----------------------------------------------------------------------------

module signed_int_to_decimal_ascii_tb;
  import s2d_pkg::*;

  localparam int RxHoldCycles = 600;
  localparam int ItemsPerPhase = 100;
  localparam int NumPhases = 4;

  // expected decimal text, one entry per character
  class decimal_text_board;
    typedef struct {
      logic [CharWidth-1:0] code;
      logic                 last;
    } text_char_t;

    text_char_t  pending_chars[$];
    int unsigned mismatches = 0;

    function void note_value(logic [ValueWidth-1:0] raw);
      logic [ValueWidth-1:0] mag;
      logic [3:0]            digs[NumDigits];
      int                    nd;
      text_char_t            c;
      // the most negative value wraps to its own magnitude as unsigned
      mag = raw[ValueWidth-1] ? (32'd0 - raw) : raw;
      nd = 0;
      do begin
        digs[nd] = 4'(mag % 10);
        mag = mag / 10;
        nd++;
      end while (mag != 0);
      if (raw[ValueWidth-1]) begin
        c.code = CharMinus;
        c.last = 1'b0;
        pending_chars.push_back(c);
      end
      for (int i = nd - 1; i >= 0; i--) begin
        c.code = CharZero + 8'(digs[i]);
        c.last = (i == 0);
        pending_chars.push_back(c);
      end
    endfunction

    function void check_char(logic [CharWidth-1:0] code, logic last);
      text_char_t want;
      if (pending_chars.size() == 0) begin
        $error("unexpected item: character %0d last %0b", code, last);
        mismatches++;
        return;
      end
      want = pending_chars.pop_front();
      if (code !== want.code) begin
        $error("character mismatch: expected %0d, actual %0d", want.code, code);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last mismatch: expected %0b, actual %0b", want.last, last);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_chars.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  s2d_in_if  in_ch ();
  s2d_out_if out_ch ();

  signed_int_to_decimal_ascii i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  decimal_text_board board;

  int tx_idle_pct   = 0;
  int rx_stall_pct  = 0;
  int hold_requests = 0;

  // receiver: random stalls plus long hold-offs on request
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = RxHoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      board.check_char(out_ch.character, out_ch.last);
    end
  end

  task automatic send_value(input logic [ValueWidth-1:0] v);
    int gap;
    gap = 0;
    while (gap < 60 && $urandom_range(99) < tx_idle_pct) gap++;
    @(negedge clk_i);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    do @(posedge clk_i); while (!in_ch.ready);
    board.note_value(v);
  endtask

  // sender stops offering until the whole text has come out
  task automatic wait_drained();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (board.pending() > 0) @(posedge clk_i);
  endtask

  function automatic logic [ValueWidth-1:0] pick_value();
    logic [ValueWidth-1:0] v;
    int                    nbits;
    case ($urandom_range(15))
      0: begin
        case ($urandom_range(3))
          0: v = 32'h0000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'h8000_0000;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      1, 2, 3: v = $urandom;
      default: begin
        // spread the mask width evenly over 1 to 32 bits
        nbits = $urandom_range(1, 32);
        v = $urandom & (32'hFFFF_FFFF >> (32 - nbits));
        if ($urandom_range(1)) v = 32'd0 - v;
      end
    endcase
    return v;
  endfunction

  int directed_values[] = '{
    0, 1, -1, 7, -8, 9, 10, -10, 99, -100, 12345,
    1000000000, -1000000000, 999999999, -999999999,
    2147483647, -2147483647, 32'sh8000_0000,
    1234567890, -1987654321, 32'sh5555_5555, 32'shAAAA_AAAA
  };

  initial begin
    board = new();
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 83; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 83; end
        default: begin tx_idle_pct = 29; rx_stall_pct = 29; end
      endcase
      if (phase == 0) begin
        foreach (directed_values[i]) send_value(directed_values[i]);
        wait_drained();
        // output held off while the sender keeps offering
        hold_requests++;
        repeat (30) send_value(pick_value());
        wait_drained();
      end
      repeat (ItemsPerPhase) send_value(pick_value());
      wait_drained();
    end

    repeat (60) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
